// ===== src/eii_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4 header inserter.
package eii_pkg;

    localparam int unsigned HdrBytes   = 34;
    localparam int unsigned IpHdrBytes = 20;
    localparam int unsigned IdxW       = $clog2(HdrBytes);
    localparam int unsigned ChkWords   = 10;

    typedef logic [IdxW-1:0] t_hdr_idx;

    localparam t_hdr_idx     HdrLastIdx = t_hdr_idx'(HdrBytes - 1);
    localparam t_hdr_idx     ChkLastIdx = t_hdr_idx'(ChkWords);
    localparam logic [15:0]  MaxPayload = 16'd65515;
    localparam logic [15:0]  IpHdrLen   = 16'(IpHdrBytes);
    localparam logic [16:0]  FrameHdrLen = 17'(HdrBytes);

    // register file defaults
    localparam logic [47:0] DestMacRst   = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] SourceMacRst = 48'h1234_5678_9ABC;
    localparam logic [31:0] SourceIpRst  = 32'hC0A8_0001;
    localparam logic [31:0] DestIpRst    = 32'hC0A8_0002;
    localparam logic [15:0] IdentRst     = 16'h1234;
    localparam logic [7:0]  HopLimitRst  = 8'd64;
    localparam logic [7:0]  ProtoRst     = 8'd17;

    localparam int unsigned ApbAddrW = 6;
    localparam int unsigned ApbDataW = 64;

    typedef enum logic [2:0] {
        REG_DEST_MAC   = 3'd0,
        REG_SOURCE_MAC = 3'd1,
        REG_SOURCE_IP  = 3'd2,
        REG_DEST_IP    = 3'd3,
        REG_IDENT      = 3'd4,
        REG_HOP_LIMIT  = 3'd5,
        REG_PROTO      = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] ident;
        logic [7:0]  hop_limit;
        logic [7:0]  proto_number;
    } t_hdr_cfg;

endpackage

// ===== src/eii_cfg_regs.sv =====
// APB register file holding the header fields.
module eii_cfg_regs
    import eii_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    output t_hdr_cfg            o_cfg
);

    t_hdr_cfg r_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[ApbAddrW-1:3]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_mac     <= DestMacRst;
            r_cfg.source_mac   <= SourceMacRst;
            r_cfg.source_ip    <= SourceIpRst;
            r_cfg.dest_ip      <= DestIpRst;
            r_cfg.ident        <= IdentRst;
            r_cfg.hop_limit    <= HopLimitRst;
            r_cfg.proto_number <= ProtoRst;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEST_MAC:   r_cfg.dest_mac     <= pwdata[47:0];
                REG_SOURCE_MAC: r_cfg.source_mac   <= pwdata[47:0];
                REG_SOURCE_IP:  r_cfg.source_ip    <= pwdata[31:0];
                REG_DEST_IP:    r_cfg.dest_ip      <= pwdata[31:0];
                REG_IDENT:      r_cfg.ident        <= pwdata[15:0];
                REG_HOP_LIMIT:  r_cfg.hop_limit    <= pwdata[7:0];
                REG_PROTO:      r_cfg.proto_number <= pwdata[7:0];
                default: ;  // unmapped slot, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEST_MAC:   prdata = ApbDataW'(r_cfg.dest_mac);
            REG_SOURCE_MAC: prdata = ApbDataW'(r_cfg.source_mac);
            REG_SOURCE_IP:  prdata = ApbDataW'(r_cfg.source_ip);
            REG_DEST_IP:    prdata = ApbDataW'(r_cfg.dest_ip);
            REG_IDENT:      prdata = ApbDataW'(r_cfg.ident);
            REG_HOP_LIMIT:  prdata = ApbDataW'(r_cfg.hop_limit);
            REG_PROTO:      prdata = ApbDataW'(r_cfg.proto_number);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== src/eth_ipv4_header_inserter_unit.sv =====
// Ethernet/IPv4 header inserter: header generation, checksum and payload pass-through.
//
// A start transfer (tuser = 0) makes the block send the 34-byte Ethernet and
// IPv4 header, one byte per cycle while m_tready allows, most significant byte
// first; the input stays stalled until the last header byte goes out. The IPv4
// checksum is accumulated one header word per cycle during the first ten header
// bytes, well before it goes out. Payload transfers (tuser = 1) then pass at one
// byte per cycle while m_tready allows, through the input register and the output
// register; the last counted byte carries tlast (for a zero length, the last header
// byte does), and a byte with no open packet is echoed with the error flag in tuser.
// A start with a length above 65515 is clamped to 65515. Registers sit at byte address
// 8*i on a 64-bit APB port and should only be written while the stream is idle.
module eth_ipv4_header_inserter_unit
    import eii_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [15:0] payload_length, [23:16] data_byte
    input  logic                s_tuser,   // [0] operation
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [7:0] out_byte, [24:8] frame_length, zero pad
    output logic                m_tlast,
    output logic                m_tuser    // [0] error
);

    t_hdr_cfg w_cfg;

    eii_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register
    logic        r_in_valid;
    t_op         r_in_op;
    logic [15:0] r_in_len;
    logic [7:0]  r_in_byte;

    // packet state
    t_hdr_idx    r_idx;
    logic [15:0] r_acc;
    logic [15:0] r_remaining;
    logic [16:0] r_total;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [16:0] r_out_flen;
    logic        r_out_err;

    logic [7:0]  n_out_byte;
    logic        n_out_last;
    logic [16:0] n_out_flen;
    logic        n_out_err;

    logic        w_adv;
    logic        w_fire;
    logic        w_consume;
    logic        w_hdr_last;
    logic        w_accept;
    logic [15:0] w_len_sat;
    logic [15:0] w_tot;
    logic [16:0] w_flen;
    logic [15:0] w_word;
    logic [16:0] w_sum;
    logic [15:0] w_acc_next;
    logic [15:0] w_csum;
    logic [7:0]  w_hdr_byte;

    assign w_adv      = !r_out_valid || m_tready;
    assign w_fire     = r_in_valid && w_adv;
    assign w_hdr_last = (r_idx == HdrLastIdx);
    assign w_consume  = (r_in_op == OP_PAYLOAD) || w_hdr_last;
    assign s_tready   = !r_in_valid || (w_adv && w_consume);
    assign w_accept   = s_tvalid && s_tready;

    assign w_len_sat = (s_tdata[15:0] > MaxPayload) ? MaxPayload : s_tdata[15:0];
    assign w_tot     = r_in_len + IpHdrLen;
    assign w_flen    = {1'b0, r_in_len} + FrameHdrLen;

    // one IPv4 header word per cycle, while the output advances, into the end-around-carry sum
    always_comb begin
        case (r_idx)
            t_hdr_idx'(0): w_word = 16'h4500;
            t_hdr_idx'(1): w_word = w_tot;
            t_hdr_idx'(2): w_word = w_cfg.ident;
            t_hdr_idx'(3): w_word = 16'h4000;
            t_hdr_idx'(4): w_word = {w_cfg.hop_limit, w_cfg.proto_number};
            t_hdr_idx'(6): w_word = w_cfg.source_ip[31:16];
            t_hdr_idx'(7): w_word = w_cfg.source_ip[15:0];
            t_hdr_idx'(8): w_word = w_cfg.dest_ip[31:16];
            t_hdr_idx'(9): w_word = w_cfg.dest_ip[15:0];
            default:       w_word = 16'h0000;
        endcase
    end

    assign w_sum      = {1'b0, r_acc} + {1'b0, w_word};
    assign w_acc_next = w_sum[16] ? (w_sum[15:0] + 16'd1) : w_sum[15:0];
    assign w_csum     = ~r_acc;

    always_comb begin
        case (r_idx)
            t_hdr_idx'(0):  w_hdr_byte = w_cfg.dest_mac[47:40];
            t_hdr_idx'(1):  w_hdr_byte = w_cfg.dest_mac[39:32];
            t_hdr_idx'(2):  w_hdr_byte = w_cfg.dest_mac[31:24];
            t_hdr_idx'(3):  w_hdr_byte = w_cfg.dest_mac[23:16];
            t_hdr_idx'(4):  w_hdr_byte = w_cfg.dest_mac[15:8];
            t_hdr_idx'(5):  w_hdr_byte = w_cfg.dest_mac[7:0];
            t_hdr_idx'(6):  w_hdr_byte = w_cfg.source_mac[47:40];
            t_hdr_idx'(7):  w_hdr_byte = w_cfg.source_mac[39:32];
            t_hdr_idx'(8):  w_hdr_byte = w_cfg.source_mac[31:24];
            t_hdr_idx'(9):  w_hdr_byte = w_cfg.source_mac[23:16];
            t_hdr_idx'(10): w_hdr_byte = w_cfg.source_mac[15:8];
            t_hdr_idx'(11): w_hdr_byte = w_cfg.source_mac[7:0];
            t_hdr_idx'(12): w_hdr_byte = 8'h08;
            t_hdr_idx'(13): w_hdr_byte = 8'h00;
            t_hdr_idx'(14): w_hdr_byte = 8'h45;
            t_hdr_idx'(15): w_hdr_byte = 8'h00;
            t_hdr_idx'(16): w_hdr_byte = w_tot[15:8];
            t_hdr_idx'(17): w_hdr_byte = w_tot[7:0];
            t_hdr_idx'(18): w_hdr_byte = w_cfg.ident[15:8];
            t_hdr_idx'(19): w_hdr_byte = w_cfg.ident[7:0];
            t_hdr_idx'(20): w_hdr_byte = 8'h40;
            t_hdr_idx'(21): w_hdr_byte = 8'h00;
            t_hdr_idx'(22): w_hdr_byte = w_cfg.hop_limit;
            t_hdr_idx'(23): w_hdr_byte = w_cfg.proto_number;
            t_hdr_idx'(24): w_hdr_byte = w_csum[15:8];
            t_hdr_idx'(25): w_hdr_byte = w_csum[7:0];
            t_hdr_idx'(26): w_hdr_byte = w_cfg.source_ip[31:24];
            t_hdr_idx'(27): w_hdr_byte = w_cfg.source_ip[23:16];
            t_hdr_idx'(28): w_hdr_byte = w_cfg.source_ip[15:8];
            t_hdr_idx'(29): w_hdr_byte = w_cfg.source_ip[7:0];
            t_hdr_idx'(30): w_hdr_byte = w_cfg.dest_ip[31:24];
            t_hdr_idx'(31): w_hdr_byte = w_cfg.dest_ip[23:16];
            t_hdr_idx'(32): w_hdr_byte = w_cfg.dest_ip[15:8];
            t_hdr_idx'(33): w_hdr_byte = w_cfg.dest_ip[7:0];
            default:        w_hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (r_in_op == OP_START) begin
            n_out_byte = w_hdr_byte;
            n_out_last = w_hdr_last && (r_in_len == 16'd0);
            n_out_flen = w_flen;
            n_out_err  = 1'b0;
        end else begin
            n_out_byte = r_in_byte;
            n_out_flen = r_total;
            // stray byte: nothing left in the open packet
            n_out_err  = (r_remaining == 16'd0);
            n_out_last = (r_remaining == 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_acc       <= 16'hFFFF;
            r_remaining <= 16'd0;
            r_total     <= FrameHdrLen;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                if (r_in_op == OP_START) begin
                    if (w_hdr_last) begin
                        r_idx       <= '0;
                        r_acc       <= 16'hFFFF;
                        r_remaining <= r_in_len;
                        r_total     <= w_flen;
                    end else begin
                        r_idx <= r_idx + t_hdr_idx'(1);
                        if (r_idx < ChkLastIdx) begin
                            r_acc <= w_acc_next;
                        end
                    end
                end else if (r_remaining != 16'd0) begin
                    r_remaining <= r_remaining - 16'd1;
                end
            end

            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire && w_consume) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= t_op'(s_tuser);
            r_in_len  <= w_len_sat;
            r_in_byte <= s_tdata[23:16];
        end
        if (w_fire) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_out_flen <= n_out_flen;
            r_out_err  <= n_out_err;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_flen, r_out_byte};
    assign m_tlast  = r_out_last;
    assign m_tuser  = r_out_err;

endmodule
